// ----- design/vea_pkg.sv -----
// Shared types and constants for the viewshed event angle and distance unit.
package vea_pkg;

	// Event kind codes carried on the input tuser; the unused code acts as an exit event.
	typedef enum logic [1:0] {
		KIND_ENTER  = 2'd0,
		KIND_CENTER = 2'd1,
		KIND_EXIT   = 2'd2
	} event_kind_t;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 1;
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_VIEWPOINT_ROW = 1'b0,
		REG_VIEWPOINT_COL = 1'b1
	} cfg_reg_t;

	// Width of the squared distance result.
	localparam int DIST_BITS = 31;

	// Fraction bits added to the offsets before the CORDIC iterations.
	localparam int CORDIC_FRAC = 24;
	localparam int ATAN_LEN    = 24;

	// Quarter-turn starting angles, 2^32 units per turn.
	localparam logic [31:0] TURN_0   = 32'h0000_0000;
	localparam logic [31:0] TURN_90  = 32'h4000_0000;
	localparam logic [31:0] TURN_180 = 32'h8000_0000;
	localparam logic [31:0] TURN_270 = 32'hC000_0000;

	// atan(2^-i) as a fraction of a turn, scaled by 2^32 and rounded.
	localparam logic [31:0] ATAN_TURN32 [0:ATAN_LEN-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage

// ----- design/viewshed_event_angle_distance_top.sv -----
// Top level of the viewshed event angle and distance unit: prep, quadrant fold, CORDIC, output buffer.
//
// Each transfer on the slave stream is one grid-cell event; the unit returns one result per event
// on the master stream, in order. The event point is the cell center or a half-cell corner chosen
// by the event kind and by where the cell lies around the configured viewpoint. The result holds
// the counter-clockwise angle of that point seen from the viewpoint center (y axis down on the
// grid, 2^ANGLE_BITS units per turn, rounded) and the squared distance in quarter-cell units.
// Events in the viewpoint cell give zero angle and distance with the tuser flag set. The unit
// takes one event per clock cycle unless the output buffer is full; each event passes through one
// register for each CORDIC iteration plus four stages for offset preparation, quadrant folding
// with the squaring multipliers, rounding and the output buffer.
// The pipeline advances as a whole and only halts when the two-entry output buffer is full.
// Write the viewpoint registers only while no event is in flight.
module viewshed_event_angle_distance_top #(
	parameter int COORD_BITS    = 14,
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,

	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [vea_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_wdata,

	// Event input stream.
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]             s_tdata,  // event_row, event_col
	input  logic [1:0]                                    s_tuser,  // event_kind
	input  logic                                          s_tlast,  // last_in

	// Result output stream.
	output logic                                                     m_tvalid,
	input  logic                                                     m_tready,
	output logic [((ANGLE_BITS+vea_pkg::DIST_BITS+7)/8)*8-1:0]       m_tdata,  // angle_units, squared_distance
	output logic                                                     m_tuser,  // is_viewpoint_cell
	output logic                                                     m_tlast   // last_out
);

	localparam int DW     = COORD_BITS + 2;            // half-cell offset width, signed
	localparam int CW     = COORD_BITS + 28;           // CORDIC datapath width, signed
	localparam int PW     = 2 * DW;                    // square width
	localparam int SW     = (PW + 1 > vea_pkg::DIST_BITS) ? PW + 1 : vea_pkg::DIST_BITS;
	localparam int MDW    = ((ANGLE_BITS + vea_pkg::DIST_BITS + 7) / 8) * 8;
	localparam logic [31:0] ROUND_HALF = 32'd1 << (31 - ANGLE_BITS);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [COORD_BITS-1:0] vp_row_q, vp_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_row_q <= '0;
			vp_col_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == vea_pkg::REG_VIEWPOINT_ROW) begin
				vp_row_q <= cfg_wdata;
			end else begin
				vp_col_q <= cfg_wdata;
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipeline enable and output buffer occupancy
	// ------------------------------------------------------------------
	logic [1:0] count_q;
	logic       en;
	logic       push;
	logic       pop;
	logic       valid_s4;

	assign en       = (count_q != 2'd2);
	assign s_tready = en;
	assign push     = en && valid_s4;
	assign pop      = m_tvalid && m_tready;

	// ------------------------------------------------------------------
	// Stage 1: offsets from the viewpoint and corner selection
	// ------------------------------------------------------------------
	logic [COORD_BITS-1:0]   ev_row, ev_col;
	logic signed [COORD_BITS:0] rd, cd;
	logic                    r_lt, r_eq, c_lt, c_eq;
	logic                    ro_neg, co_neg;
	logic                    is_enter, is_center;
	logic signed [DW-1:0]    ro, co, dr_c, dc_c;

	assign ev_row    = s_tdata[COORD_BITS-1:0];
	assign ev_col    = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign is_enter  = (s_tuser == vea_pkg::KIND_ENTER);
	assign is_center = (s_tuser == vea_pkg::KIND_CENTER);

	always_comb begin
		rd   = $signed({1'b0, ev_row}) - $signed({1'b0, vp_row_q});
		cd   = $signed({1'b0, ev_col}) - $signed({1'b0, vp_col_q});
		r_lt = rd[COORD_BITS];
		r_eq = (rd == '0);
		c_lt = cd[COORD_BITS];
		c_eq = (cd == '0);

		// Corner choice per octant region; a set bit means minus one half cell.
		priority if (r_lt && c_lt) begin
			ro_neg = is_enter;
			co_neg = !is_enter;
		end else if (r_lt && c_eq) begin
			ro_neg = 1'b0;
			co_neg = !is_enter;
		end else if (r_lt) begin
			ro_neg = !is_enter;
			co_neg = !is_enter;
		end else if (r_eq && !c_lt) begin
			ro_neg = !is_enter;
			co_neg = 1'b1;
		end else if (!r_eq && !c_lt && !c_eq) begin
			ro_neg = !is_enter;
			co_neg = is_enter;
		end else if (!r_eq && c_eq) begin
			ro_neg = 1'b1;
			co_neg = is_enter;
		end else if (!r_eq) begin
			ro_neg = is_enter;
			co_neg = is_enter;
		end else begin
			ro_neg = is_enter;
			co_neg = 1'b0;
		end

		if (is_center) begin
			ro = '0;
			co = '0;
		end else begin
			ro = ro_neg ? -DW'(1) : DW'(1);
			co = co_neg ? -DW'(1) : DW'(1);
		end
		dr_c = (DW'(rd) <<< 1) + ro;
		dc_c = (DW'(cd) <<< 1) + co;
	end

	logic signed [DW-1:0] dr_s1, dc_s1;
	logic                 vp_s1, last_s1, valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s1   <= dr_c;
			dc_s1   <= dc_c;
			vp_s1   <= r_eq && c_eq;
			last_s1 <= s_tlast;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: fold into the first quadrant, square the offsets
	// ------------------------------------------------------------------
	logic signed [DW-1:0] x0, y0, xr, yr;
	logic [31:0]          acc_init;
	logic signed [PW-1:0] sq_r, sq_c;

	always_comb begin
		x0 = dc_s1;
		y0 = -dr_s1;
		if (x0 > 0 && y0 >= 0) begin
			xr       = x0;
			yr       = y0;
			acc_init = vea_pkg::TURN_0;
		end else if (x0 <= 0 && y0 > 0) begin
			xr       = y0;
			yr       = -x0;
			acc_init = vea_pkg::TURN_90;
		end else if (x0 < 0 && y0 <= 0) begin
			xr       = -x0;
			yr       = -y0;
			acc_init = vea_pkg::TURN_180;
		end else begin
			xr       = -y0;
			yr       = x0;
			acc_init = vea_pkg::TURN_270;
		end
		sq_r = dr_s1 * dr_s1;
		sq_c = dc_s1 * dc_s1;
	end

	logic signed [DW-1:0] x_s2, y_s2;
	logic [31:0]          acc_s2;
	logic                 axis_s2;
	logic [PW-1:0]        sqr_s2, sqc_s2;
	logic                 vp_s2, last_s2, valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= xr;
			y_s2    <= yr;
			acc_s2  <= acc_init;
			axis_s2 <= (xr == '0) || (yr == '0);
			sqr_s2  <= sq_r;
			sqc_s2  <= sq_c;
			vp_s2   <= vp_s1;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: one register per CORDIC vectoring iteration
	// ------------------------------------------------------------------
	logic signed [CW-1:0]           cx_s3   [1:CORDIC_STAGES];
	logic signed [CW-1:0]           cy_s3   [1:CORDIC_STAGES];
	logic [31:0]                    cacc_s3 [1:CORDIC_STAGES];
	logic [vea_pkg::DIST_BITS-1:0]  dist_s3 [1:CORDIC_STAGES];
	logic [CORDIC_STAGES:1]         axis_s3;
	logic [CORDIC_STAGES:1]         vp_s3;
	logic [CORDIC_STAGES:1]         last_s3;
	logic [CORDIC_STAGES:1]         valid_s3;

	logic [SW-1:0] dist_sum;
	assign dist_sum = SW'(sqr_s2) + SW'(sqc_s2);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		logic signed [CW-1:0]          xin, yin, xs, ys, xn, yn;
		logic [31:0]                   ain, an;
		logic [vea_pkg::DIST_BITS-1:0] din;
		logic                          axin, vpin, lin, vin;

		if (i == 0) begin : g_first
			assign xin  = CW'(x_s2) <<< vea_pkg::CORDIC_FRAC;
			assign yin  = CW'(y_s2) <<< vea_pkg::CORDIC_FRAC;
			assign ain  = acc_s2;
			assign din  = dist_sum[vea_pkg::DIST_BITS-1:0];
			assign axin = axis_s2;
			assign vpin = vp_s2;
			assign lin  = last_s2;
			assign vin  = valid_s2;
		end else begin : g_next
			assign xin  = cx_s3[i];
			assign yin  = cy_s3[i];
			assign ain  = cacc_s3[i];
			assign din  = dist_s3[i];
			assign axin = axis_s3[i];
			assign vpin = vp_s3[i];
			assign lin  = last_s3[i];
			assign vin  = valid_s3[i];
		end

		always_comb begin
			xs = xin >>> i;
			ys = yin >>> i;
			if (axin) begin
				xn = xin;
				yn = yin;
				an = ain;
			end else if (yin > 0) begin
				xn = xin + ys;
				yn = yin - xs;
				an = ain + vea_pkg::ATAN_TURN32[i];
			end else begin
				xn = xin - ys;
				yn = yin + xs;
				an = ain - vea_pkg::ATAN_TURN32[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s3[i+1] <= 1'b0;
			end else if (en) begin
				valid_s3[i+1] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cx_s3[i+1]   <= xn;
				cy_s3[i+1]   <= yn;
				cacc_s3[i+1] <= an;
				dist_s3[i+1] <= din;
				axis_s3[i+1] <= axin;
				vp_s3[i+1]   <= vpin;
				last_s3[i+1] <= lin;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: round the angle, clear results of the viewpoint cell
	// ------------------------------------------------------------------
	logic [31:0] acc_rnd;
	assign acc_rnd = cacc_s3[CORDIC_STAGES] + ROUND_HALF;

	logic [ANGLE_BITS-1:0]         ang_s4;
	logic [vea_pkg::DIST_BITS-1:0] dist_s4;
	logic                          vp_s4, last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s4  <= vp_s3[CORDIC_STAGES] ? '0 : acc_rnd[31 -: ANGLE_BITS];
			dist_s4 <= vp_s3[CORDIC_STAGES] ? '0 : dist_s3[CORDIC_STAGES];
			vp_s4   <= vp_s3[CORDIC_STAGES];
			last_s4 <= last_s3[CORDIC_STAGES];
		end
	end

	// ------------------------------------------------------------------
	// Two-entry output buffer
	// ------------------------------------------------------------------
	logic [MDW-1:0] res_data;
	assign res_data = MDW'({dist_s4, ang_s4});

	logic [MDW-1:0] buf0_data_q, buf1_data_q;
	logic           buf0_user_q, buf1_user_q;
	logic           buf0_last_q, buf1_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && count_q == 2'd1) begin
				buf0_data_q <= res_data;
				buf0_user_q <= vp_s4;
				buf0_last_q <= last_s4;
			end else begin
				buf0_data_q <= buf1_data_q;
				buf0_user_q <= buf1_user_q;
				buf0_last_q <= buf1_last_q;
			end
			if (push && count_q == 2'd2) begin
				buf1_data_q <= res_data;
				buf1_user_q <= vp_s4;
				buf1_last_q <= last_s4;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				buf0_data_q <= res_data;
				buf0_user_q <= vp_s4;
				buf0_last_q <= last_s4;
			end else begin
				buf1_data_q <= res_data;
				buf1_user_q <= vp_s4;
				buf1_last_q <= last_s4;
			end
		end
	end

	assign m_tvalid = (count_q != 2'd0);
	assign m_tdata  = buf0_data_q;
	assign m_tuser  = buf0_user_q;
	assign m_tlast  = buf0_last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// The input side only stalls while finished results wait at the output.
	assert property (@(posedge clk) disable iff (!arst_n) !s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	// A viewpoint-cell result carries zero angle and zero distance.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("viewpoint-cell result is not zero");

	// A transfer out with nothing arriving frees exactly one buffer entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 2'd1))
		else $error("output buffer count out of step");

endmodule

// ----- dv/viewshed_event_angle_distance_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the viewshed event angle and distance unit.
module viewshed_event_angle_distance_top_tb;

	localparam int COORD_BITS    = 14;
	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int STALL_CYCLES  = 300;
	localparam int MAX_REPORTS   = 10;
	// The spare kind code is handled like an exit event.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct {
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
		logic [1:0]            kind;
		logic                  last;
	} grid_event_t;

	typedef struct {
		logic [ANGLE_BITS-1:0]         angle;
		logic [vea_pkg::DIST_BITS-1:0] sq_dist;
		logic                          on_viewpoint;
		logic                          last;
	} sight_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	vea_pkg::cfg_reg_t cfg_index;
	logic [COORD_BITS-1:0] cfg_wdata;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;  // event_row, event_col
	logic [1:0] s_tuser = '0;   // event_kind
	logic s_tlast = 1'b0;       // last_in
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;  // angle_units, squared_distance
	logic m_tuser;         // is_viewpoint_cell
	logic m_tlast;         // last_out

	grid_event_t pending_events[$];
	sight_result_t expected_results[$];
	logic [COORD_BITS-1:0] vp_row = '0;
	logic [COORD_BITS-1:0] vp_col = '0;
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int stall_left = 0;
	logic stall_kick;
	logic in_taken = 1'b0;

	viewshed_event_angle_distance_top #(
		.COORD_BITS(COORD_BITS),
		.ANGLE_BITS(ANGLE_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Binary angle of (x, y) with y up, 2^32 units per turn, by CORDIC vectoring.
	function automatic logic [31:0] sweep_angle(longint x, longint y);
		logic [31:0] acc;
		longint t;
		longint xs;
		longint ys;
		if (x > 0 && y >= 0) begin
			acc = vea_pkg::TURN_0;
		end else if (x <= 0 && y > 0) begin
			t = x;
			x = y;
			y = -t;
			acc = vea_pkg::TURN_90;
		end else if (x < 0 && y <= 0) begin
			x = -x;
			y = -y;
			acc = vea_pkg::TURN_180;
		end else begin
			t = x;
			x = -y;
			y = t;
			acc = vea_pkg::TURN_270;
		end
		if (x == 0 || y == 0)
			return acc;
		x = x <<< vea_pkg::CORDIC_FRAC;
		y = y <<< vea_pkg::CORDIC_FRAC;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				acc = acc + vea_pkg::ATAN_TURN32[i];
			end else begin
				x = x - ys;
				y = y + xs;
				acc = acc - vea_pkg::ATAN_TURN32[i];
			end
		end
		return acc;
	endfunction

	function automatic sight_result_t predict_result(grid_event_t ev, logic [COORD_BITS-1:0] vr,
			logic [COORD_BITS-1:0] vc);
		sight_result_t res;
		longint ro;
		longint co;
		longint dr;
		longint dc;
		longint d2;
		logic enter;
		logic [31:0] acc;
		res.last = ev.last;
		if (ev.row == vr && ev.col == vc) begin
			res.angle = '0;
			res.sq_dist = '0;
			res.on_viewpoint = 1'b1;
			return res;
		end
		ro = 0;
		co = 0;
		enter = (ev.kind == vea_pkg::KIND_ENTER);
		// Corner choice: depends on the octant around the viewpoint and on enter versus exit.
		if (ev.kind != vea_pkg::KIND_CENTER) begin
			if (ev.row < vr && ev.col < vc) begin
				ro = enter ? -1 : 1;
				co = enter ? 1 : -1;
			end else if (ev.row < vr && ev.col == vc) begin
				ro = 1;
				co = enter ? 1 : -1;
			end else if (ev.row < vr) begin
				ro = enter ? 1 : -1;
				co = enter ? 1 : -1;
			end else if (ev.row == vr && ev.col > vc) begin
				ro = enter ? 1 : -1;
				co = -1;
			end else if (ev.row > vr && ev.col > vc) begin
				ro = enter ? 1 : -1;
				co = enter ? -1 : 1;
			end else if (ev.row > vr && ev.col == vc) begin
				ro = -1;
				co = enter ? -1 : 1;
			end else if (ev.row > vr) begin
				ro = enter ? -1 : 1;
				co = enter ? -1 : 1;
			end else begin
				ro = enter ? -1 : 1;
				co = 1;
			end
		end
		dr = 2 * (longint'(ev.row) - longint'(vr)) + ro;
		dc = 2 * (longint'(ev.col) - longint'(vc)) + co;
		d2 = dr * dr + dc * dc;
		res.sq_dist = d2[vea_pkg::DIST_BITS-1:0];
		// Grid rows grow downward, so the row offset is negated to get y up.
		acc = sweep_angle(dc, -dr) + (32'd1 << (31 - ANGLE_BITS));
		res.angle = acc[31 -: ANGLE_BITS];
		res.on_viewpoint = 1'b0;
		return res;
	endfunction

	function automatic grid_event_t random_event(int vr, int vc);
		grid_event_t ev;
		int r;
		int c;
		int pick;
		pick = $urandom_range(99);
		if (pick < 30) begin
			r = vr + int'($urandom_range(6)) - 3;
			c = vc + int'($urandom_range(6)) - 3;
		end else if (pick < 45) begin
			if ($urandom_range(1) == 1) begin
				r = vr;
				c = $urandom_range(COORD_MAX);
			end else begin
				r = $urandom_range(COORD_MAX);
				c = vc;
			end
		end else begin
			r = $urandom_range(COORD_MAX);
			c = $urandom_range(COORD_MAX);
		end
		r = (r < 0) ? 0 : (r > COORD_MAX) ? COORD_MAX : r;
		c = (c < 0) ? 0 : (c > COORD_MAX) ? COORD_MAX : c;
		ev.row = r[COORD_BITS-1:0];
		ev.col = c[COORD_BITS-1:0];
		ev.kind = 2'($urandom_range(3));
		ev.last = ($urandom_range(7) == 0);
		return ev;
	endfunction

	task automatic queue_event(int r, int c, logic [1:0] kind, logic last);
		grid_event_t ev;
		ev.row = r[COORD_BITS-1:0];
		ev.col = c[COORD_BITS-1:0];
		ev.kind = kind;
		ev.last = last;
		pending_events.push_back(ev);
	endtask

	task automatic queue_random(int count, int vr, int vc);
		for (int i = 0; i < count; i++)
			pending_events.push_back(random_event(vr, vc));
	endtask

	task automatic write_reg(vea_pkg::cfg_reg_t idx, int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[COORD_BITS-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Event driver: a new event goes out once the previous one has been transferred.
	always @(negedge clk) begin
		grid_event_t ev;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (pending_events.size() != 0 && $urandom_range(99) >= send_idle) begin
				ev = pending_events.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {4'b0, ev.col, ev.row};
				s_tuser <= ev.kind;
				s_tlast <= ev.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_kick)
			stall_left <= STALL_CYCLES;
		else if (stall_left != 0)
			stall_left <= stall_left - 1;
	end

	always @(negedge clk) begin
		m_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle);
	end

	// Monitor: tracks register writes, predicts on input transfers, checks output transfers.
	always @(posedge clk) begin
		grid_event_t ev;
		sight_result_t want;
		sight_result_t got;
		in_taken = arst_n && s_tvalid && s_tready;
		if (cfg_we) begin
			unique case (cfg_index)
				vea_pkg::REG_VIEWPOINT_ROW: vp_row = cfg_wdata;
				vea_pkg::REG_VIEWPOINT_COL: vp_col = cfg_wdata;
			endcase
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.angle = m_tdata[ANGLE_BITS-1:0];
			got.sq_dist = m_tdata[ANGLE_BITS +: vea_pkg::DIST_BITS];
			got.on_viewpoint = m_tuser;
			got.last = m_tlast;
			if (expected_results.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: result with nothing expected: angle %0d dist %0d vp %b last %b",
						$realtime, got.angle, got.sq_dist, got.on_viewpoint, got.last);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (got.angle !== want.angle || got.sq_dist !== want.sq_dist ||
						got.on_viewpoint !== want.on_viewpoint || got.last !== want.last) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: mismatch angle %0d/%0d dist %0d/%0d vp %b/%b last %b/%b (exp/act)",
							$realtime, want.angle, got.angle, want.sq_dist, got.sq_dist,
							want.on_viewpoint, got.on_viewpoint, want.last, got.last);
					mismatches++;
				end
			end
		end
		if (in_taken) begin
			ev.row = s_tdata[COORD_BITS-1:0];
			ev.col = s_tdata[2*COORD_BITS-1:COORD_BITS];
			ev.kind = s_tuser;
			ev.last = s_tlast;
			expected_results.push_back(predict_result(ev, vp_row, vp_col));
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("viewshed_event_angle_distance_top_tb failed");
			$finish;
		end
	end

	initial begin
		int vr;
		int vc;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = vea_pkg::REG_VIEWPOINT_ROW;
		cfg_wdata = '0;
		stall_kick = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed events around a viewpoint in the middle of the grid.
		send_idle = 20;
		recv_idle = 72;
		vr = 8000;
		vc = 9000;
		write_reg(vea_pkg::REG_VIEWPOINT_ROW, vr);
		write_reg(vea_pkg::REG_VIEWPOINT_COL, vc);
		queue_event(vr, vc, vea_pkg::KIND_ENTER, 1'b0);
		queue_event(vr, vc, vea_pkg::KIND_CENTER, 1'b0);
		queue_event(vr, vc, vea_pkg::KIND_EXIT, 1'b0);
		queue_event(vr, vc, KIND_SPARE, 1'b1);
		// The eight neighbours cover all four quadrants and all four axis rays.
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				if (dr != 0 || dc != 0) begin
					queue_event(vr + dr, vc + dc, vea_pkg::KIND_ENTER, 1'b0);
					queue_event(vr + dr, vc + dc, vea_pkg::KIND_EXIT, 1'b0);
				end
			end
		end
		queue_event(0, 0, KIND_SPARE, 1'b0);
		queue_event(COORD_MAX, COORD_MAX, vea_pkg::KIND_CENTER, 1'b0);
		queue_event(0, COORD_MAX, vea_pkg::KIND_ENTER, 1'b0);
		queue_event(COORD_MAX, 0, vea_pkg::KIND_EXIT, 1'b1);
		queue_random(500, vr, vc);
		wait_drained();

		send_idle = 72;
		recv_idle = 20;
		write_reg(vea_pkg::REG_VIEWPOINT_ROW, 0);
		write_reg(vea_pkg::REG_VIEWPOINT_COL, 0);
		queue_random(400, 0, 0);
		wait_drained();

		// Long output stall with the input kept busy, so the pipeline fills and backs up.
		send_idle = 0;
		recv_idle = 0;
		write_reg(vea_pkg::REG_VIEWPOINT_ROW, COORD_MAX);
		write_reg(vea_pkg::REG_VIEWPOINT_COL, COORD_MAX);
		@(negedge clk);
		stall_kick <= 1'b1;
		@(negedge clk);
		stall_kick <= 1'b0;
		queue_random(400, COORD_MAX, COORD_MAX);
		wait_drained();

		vr = $urandom_range(COORD_MAX);
		vc = $urandom_range(COORD_MAX);
		write_reg(vea_pkg::REG_VIEWPOINT_ROW, vr);
		write_reg(vea_pkg::REG_VIEWPOINT_COL, vc);
		queue_random(400, vr, vc);
		wait_drained();

		repeat (CORDIC_STAGES + 8) @(posedge clk);
		if (mismatches == 0)
			$display("viewshed_event_angle_distance_top_tb passed");
		else
			$display("viewshed_event_angle_distance_top_tb failed");
		$finish;
	end

endmodule
